>>> hw/rtl/lcdw_pkg.sv
// Package for the LCD text character writer.
// Holds the shared types, codes and constants; depends on nothing.
`timescale 1ns / 1ps

package lcdw_pkg;

  // Controller command bytes.
  localparam logic [7:0] CmdAddrSet = 8'h24;
  localparam logic [7:0] CmdWrite   = 8'hC0;

  // Glyph mapping constants.
  localparam logic [7:0] GlyphOffset = 8'h20;
  localparam logic [7:0] HighChars   = 8'h80;

  // Cursor control characters.
  localparam logic [7:0] ChrNewline = 8'h0A;
  localparam logic [7:0] ChrReturn  = 8'h0D;
  localparam logic [7:0] ChrTab     = 8'h09;

  // Attribute byte codes.
  localparam logic [7:0] AttrRevBlink  = 8'h0D;
  localparam logic [7:0] AttrRev       = 8'h05;
  localparam logic [7:0] AttrBoldBlink = 8'h0F;
  localparam logic [7:0] AttrBold      = 8'h07;
  localparam logic [7:0] AttrBlink     = 8'h08;
  localparam logic [7:0] AttrNone      = 8'h00;

  // Register widths and reset values.
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned CfgIdxW       = 3;
  localparam logic [7:0]  RowWidthReset = 8'd30;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepthDefault = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegTextBase   = 3'd0,
    RegAttrBase   = 3'd1,
    RegRowWidth   = 3'd2,
    RegAttrEnable = 3'd3,
    RegReverseOn  = 3'd4,
    RegBlinkOn    = 3'd5,
    RegBoldOn     = 3'd6,
    RegSepAttr    = 3'd7
  } lcdw_reg_e;

  // Byte positions of the emitted sequence.
  typedef enum logic [3:0] {
    StTextLo   = 4'd0,
    StTextHi   = 4'd1,
    StTextSet  = 4'd2,
    StGlyph    = 4'd3,
    StGlyphWr  = 4'd4,
    StAttrLo   = 4'd5,
    StAttrHi   = 4'd6,
    StAttrSet  = 4'd7,
    StAttrByte = 4'd8,
    StAttrWr   = 4'd9,
    StNextLo   = 4'd10,
    StNextHi   = 4'd11,
    StNextSet  = 4'd12
  } lcdw_step_e;

  // One classified character as handed from the front to the back.
  typedef struct packed {
    logic [7:0]  glyph;
    logic [15:0] cell_ofs;
    logic        with_attr;
  } lcdw_cmd_t;

  // Attribute byte from the selected attribute flags.
  function automatic logic [7:0] attr_byte(input logic reverse_on, input logic blink_on,
                                           input logic bold_on);
    logic [7:0] res;
    if (reverse_on) begin
      res = blink_on ? AttrRevBlink : AttrRev;
    end else if (bold_on && blink_on) begin
      res = AttrBoldBlink;
    end else if (bold_on) begin
      res = AttrBold;
    end else if (blink_on) begin
      res = AttrBlink;
    end else begin
      res = AttrNone;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/lcdw_front.sv
// Front end of the LCD text character writer: accepts characters, tracks the cursor
// and queues one command record per printable character. Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         char_code_i,
  input  logic [7:0]         row_width_i,
  input  logic               attr_on_i,
  output logic               q_push_o,
  output lcdw_pkg::lcdw_cmd_t q_data_o,
  input  logic               q_full_i
);
  import lcdw_pkg::*;

  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic        accept;
  logic        wrap;
  logic [7:0]  col_eff;
  logic [7:0]  row_eff;
  logic [15:0] cell_ofs;
  logic [8:0]  tab_col;
  logic        is_ctrl;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  // Wrap to the next row when the column has reached the row width.
  assign wrap     = (col_q >= row_width_i);
  assign col_eff  = wrap ? 8'd0 : col_q;
  assign row_eff  = wrap ? (row_q + 8'd1) : row_q;
  assign cell_ofs = (16'(row_eff) * 16'(row_width_i)) + 16'(col_eff);
  assign tab_col  = {1'b0, col_q} + 9'd3;
  assign is_ctrl  = (char_code_i == ChrNewline) || (char_code_i == ChrReturn) ||
                    (char_code_i == ChrTab);

  // Command record for a printable character.
  always_comb begin
    q_data_o.glyph     = (char_code_i >= HighChars) ? char_code_i
                                                    : (char_code_i - GlyphOffset);
    q_data_o.cell_ofs  = cell_ofs;
    q_data_o.with_attr = attr_on_i;
  end

  assign q_push_o = accept && !is_ctrl;

  // Cursor update for each accepted character.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (char_code_i == ChrNewline) begin
        col_d = 8'd0;
        row_d = row_q + 8'd1;
      end else if (char_code_i == ChrReturn) begin
        col_d = 8'd0;
      end else if (char_code_i == ChrTab) begin
        if (tab_col < {1'b0, row_width_i}) begin
          col_d = tab_col[7:0];
        end
      end else begin
        col_d = col_eff + 8'd1;
        row_d = row_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hw/rtl/lcdw_queue.sv
// Short queue of command records between the front and the back.
// Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_queue #(
  parameter int unsigned Depth = lcdw_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lcdw_pkg::lcdw_cmd_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output lcdw_pkg::lcdw_cmd_t rdata_o,
  output logic                empty_o
);
  import lcdw_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  lcdw_cmd_t         mem_q [Depth];
  logic [AddrW-1:0]  wptr_q, wptr_d;
  logic [AddrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AddrW'(Depth - 1)) ? '0 : (wptr_q + AddrW'(1));
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AddrW'(Depth - 1)) ? '0 : (rptr_q + AddrW'(1));
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/lcdw_back.sv
// Back end of the LCD text character writer: walks each command record through
// its bus byte sequence into an output register. Depends on lcdw_pkg.
`timescale 1ns / 1ps

module lcdw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcdw_pkg::lcdw_cmd_t q_data_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  input  logic [15:0]         text_base_i,
  input  logic [15:0]         attr_base_i,
  input  logic [7:0]          row_width_i,
  input  logic [7:0]          attr_byte_i,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [7:0]          bus_byte_o,
  output logic                is_command_o,
  output logic                last_o
);
  import lcdw_pkg::*;

  lcdw_step_e  step_q, step_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q, byte_d;
  logic        cmd_q, cmd_d;
  logic        last_q, last_d;
  logic        advance;
  logic [15:0] text_addr;
  logic [15:0] attr_addr;
  logic [15:0] next_addr;
  logic [7:0]  cur_byte;
  logic        cur_cmd;
  logic        cur_last;

  assign empty_o      = !valid_q;
  assign bus_byte_o   = byte_q;
  assign is_command_o = cmd_q;
  assign last_o       = last_q;

  // Move a byte forward when a record waits and the output slot is free.
  assign advance = !q_empty_i && (!valid_q || pop_i);

  assign text_addr = text_base_i + q_data_i.cell_ofs;
  assign attr_addr = attr_base_i + q_data_i.cell_ofs;
  assign next_addr = attr_addr + 16'(row_width_i);

  // Byte decoder for the current step.
  always_comb begin
    cur_byte = 8'd0;
    cur_cmd  = 1'b0;
    cur_last = 1'b0;
    unique case (step_q)
      StTextLo:   cur_byte = text_addr[7:0];
      StTextHi:   cur_byte = text_addr[15:8];
      StTextSet:  begin
        cur_byte = CmdAddrSet;
        cur_cmd  = 1'b1;
      end
      StGlyph:    cur_byte = q_data_i.glyph;
      StGlyphWr:  begin
        cur_byte = CmdWrite;
        cur_cmd  = 1'b1;
        cur_last = !q_data_i.with_attr;
      end
      StAttrLo:   cur_byte = attr_addr[7:0];
      StAttrHi:   cur_byte = attr_addr[15:8];
      StAttrSet:  begin
        cur_byte = CmdAddrSet;
        cur_cmd  = 1'b1;
      end
      StAttrByte: cur_byte = attr_byte_i;
      StAttrWr:   begin
        cur_byte = CmdWrite;
        cur_cmd  = 1'b1;
      end
      StNextLo:   cur_byte = next_addr[7:0];
      StNextHi:   cur_byte = next_addr[15:8];
      StNextSet:  begin
        cur_byte = CmdAddrSet;
        cur_cmd  = 1'b1;
        cur_last = 1'b1;
      end
      default:    cur_last = 1'b1;
    endcase
  end

  assign q_pop_o = advance && cur_last;

  // Step sequencer and output register.
  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    cmd_d   = cmd_q;
    last_d  = last_q;
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = cur_byte;
      cmd_d   = cur_cmd;
      last_d  = cur_last;
      step_d  = cur_last ? StTextLo : lcdw_step_e'(step_q + 4'd1);
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= StTextLo;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    cmd_q  <= cmd_d;
    last_q <= last_d;
  end

endmodule

>>> hw/rtl/lcd_text_char_command_writer_unit.sv
// Top level of the LCD text character writer: configuration registers, front end,
// record queue and byte sequencer. Depends on lcdw_pkg, lcdw_front, lcdw_queue, lcdw_back.
`timescale 1ns / 1ps

// Each printable character becomes 5 bus bytes, or 13 when attributes are written
// with it; the byte sequencer delivers one byte per cycle unless a held output
// byte has not been popped. Newline, return and tab only move the cursor and are
// taken without output. The front accepts characters into a short record queue
// while earlier ones are still being sent, and full rises only when that queue is
// full. Write the configuration registers only while idle.
module lcd_text_char_command_writer_unit #(
  parameter int unsigned QueueDepth = lcdw_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lcdw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lcdw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    char_code_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    bus_byte_o,
  output logic                          is_command_o,
  output logic                          last_o
);
  import lcdw_pkg::*;

  logic [15:0] text_base_q;
  logic [15:0] attr_base_q;
  logic [7:0]  row_width_q;
  logic        attr_enable_q;
  logic        reverse_on_q;
  logic        blink_on_q;
  logic        bold_on_q;
  logic        sep_attr_q;
  logic [7:0]  attr_byte_val;

  lcdw_cmd_t   fq_data;
  logic        fq_push;
  logic        fq_full;
  lcdw_cmd_t   bq_data;
  logic        bq_empty;
  logic        bq_pop;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q   <= 16'd0;
      attr_base_q   <= 16'd0;
      row_width_q   <= RowWidthReset;
      attr_enable_q <= 1'b0;
      reverse_on_q  <= 1'b0;
      blink_on_q    <= 1'b0;
      bold_on_q     <= 1'b0;
      sep_attr_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (lcdw_reg_e'(cfg_idx_i))
        RegTextBase:   text_base_q   <= cfg_data_i;
        RegAttrBase:   attr_base_q   <= cfg_data_i;
        RegRowWidth:   row_width_q   <= cfg_data_i[7:0];
        RegAttrEnable: attr_enable_q <= cfg_data_i[0];
        RegReverseOn:  reverse_on_q  <= cfg_data_i[0];
        RegBlinkOn:    blink_on_q    <= cfg_data_i[0];
        RegBoldOn:     bold_on_q     <= cfg_data_i[0];
        RegSepAttr:    sep_attr_q    <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  assign attr_byte_val = attr_byte(reverse_on_q, blink_on_q, bold_on_q);

  // Character intake and cursor tracking.
  lcdw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .char_code_i (char_code_i),
    .row_width_i (row_width_q),
    .attr_on_i   (attr_enable_q && !sep_attr_q),
    .q_push_o    (fq_push),
    .q_data_o    (fq_data),
    .q_full_i    (fq_full)
  );

  // Record queue between the two halves.
  lcdw_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .wdata_i (fq_data),
    .full_o  (fq_full),
    .pop_i   (bq_pop),
    .rdata_o (bq_data),
    .empty_o (bq_empty)
  );

  // Bus byte sequencer.
  lcdw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_data_i     (bq_data),
    .q_empty_i    (bq_empty),
    .q_pop_o      (bq_pop),
    .text_base_i  (text_base_q),
    .attr_base_i  (attr_base_q),
    .row_width_i  (row_width_q),
    .attr_byte_i  (attr_byte_val),
    .empty_o      (empty),
    .pop_i        (pop),
    .bus_byte_o   (bus_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o)
  );

endmodule
